@@ hw/rtl/cvg_pkg.sv @@
package cvg_pkg;

  localparam int CoordW     = 16;
  localparam int RadiusW    = 17;
  localparam int TrigW      = 16;
  localparam int NumW       = 6;
  localparam int TableSize  = 36;
  localparam int SineShift  = 27;
  localparam int TrigFrac   = 14;
  localparam int RoundBias  = 8192;
  localparam int SumW       = 34;
  localparam int RootSteps  = SumW / 2;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic        [RadiusW-1:0] radius_t;
  typedef logic signed [TrigW-1:0]  trig_t;
  typedef logic        [NumW-1:0]   vnum_t;

  typedef struct packed {
    coord_t  cx;
    coord_t  cy;
    radius_t radius;
  } job_t;

  typedef enum logic [2:0] {
    FRONT_IDLE,
    FRONT_SQUARE,
    FRONT_SUM,
    FRONT_ROOT,
    FRONT_PUSH
  } front_state_e;

  function automatic trig_t cos_q14(input logic [5:0] idx);
    trig_t v;
    case (idx)
      6'd0:    v = 16'sd16384;
      6'd1:    v = 16'sd16135;
      6'd2:    v = 16'sd15396;
      6'd3:    v = 16'sd14189;
      6'd4:    v = 16'sd12551;
      6'd5:    v = 16'sd10531;
      6'd6:    v = 16'sd8192;
      6'd7:    v = 16'sd5604;
      6'd8:    v = 16'sd2845;
      6'd9:    v = 16'sd0;
      6'd10:   v = -16'sd2845;
      6'd11:   v = -16'sd5604;
      6'd12:   v = -16'sd8192;
      6'd13:   v = -16'sd10531;
      6'd14:   v = -16'sd12551;
      6'd15:   v = -16'sd14189;
      6'd16:   v = -16'sd15396;
      6'd17:   v = -16'sd16135;
      6'd18:   v = -16'sd16384;
      6'd19:   v = -16'sd16135;
      6'd20:   v = -16'sd15396;
      6'd21:   v = -16'sd14189;
      6'd22:   v = -16'sd12551;
      6'd23:   v = -16'sd10531;
      6'd24:   v = -16'sd8192;
      6'd25:   v = -16'sd5604;
      6'd26:   v = -16'sd2845;
      6'd27:   v = 16'sd0;
      6'd28:   v = 16'sd2845;
      6'd29:   v = 16'sd5604;
      6'd30:   v = 16'sd8192;
      6'd31:   v = 16'sd10531;
      6'd32:   v = 16'sd12551;
      6'd33:   v = 16'sd14189;
      6'd34:   v = 16'sd15396;
      6'd35:   v = 16'sd16135;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  function automatic coord_t sat_coord(input logic signed [20:0] v);
    coord_t r;
    if (v > 21'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -21'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/circle_vertex_generator.sv @@
// Circle vertex generator. Each input beat carries a circle center and a
// point on its rim, both signed Q3.12. The block answers with SEGMENTS+1
// output beats: the center vertex first, then the rim vertices in order of
// rising angle, the last one marked by tlast.
// The front takes the radius as the integer square root of dx*dx + dy*dy
// with a two-bit-per-cycle root unit; it first registers the differences,
// the squares and their sum, and hands the job on after the root. A two-entry
// job queue sits between the front and the vertex back end.
// While the receiver is ready, the back end emits one vertex per cycle
// through a three-stage pipeline (table lookup, multiply, round and
// saturate), so one circle occupies the output for SEGMENTS+1 beats, 37 by
// default. That output channel sets the sustained rate.
// An input beat is taken while earlier circles are still being emitted.
// When the receiver stalls, the back-end pipeline holds, the queue fills and
// then the input side drops tready. Reset empties the queue and pipeline.
module circle_vertex_generator #(
  parameter int SEGMENTS = 36
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // center_x, center_y, edge_x, edge_y
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // vertex_x, vertex_y, vertex_number, two zero bits
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import cvg_pkg::*;

  logic   push_valid, push_ready, pop_valid, pop_ready;
  job_t   push_job, pop_job;
  coord_t vx, vy;
  vnum_t  vnum;

  cvg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .center_x_i (s_axis_tdata[15:0]),
    .center_y_i (s_axis_tdata[31:16]),
    .edge_x_i   (s_axis_tdata[47:32]),
    .edge_y_i   (s_axis_tdata[63:48]),
    .job_valid_o(push_valid),
    .job_ready_i(push_ready),
    .job_o      (push_job)
  );

  cvg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_job_i  (push_job),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_job_o   (pop_job)
  );

  cvg_back #(
    .SEGMENTS(SEGMENTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (pop_valid),
    .job_ready_o    (pop_ready),
    .job_i          (pop_job),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .vertex_x_o     (vx),
    .vertex_y_o     (vy),
    .vertex_number_o(vnum),
    .last_vertex_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, vnum, vy, vx};

endmodule

@@ hw/rtl/cvg_front.sv @@
module cvg_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cvg_pkg::coord_t   center_x_i,
  input  cvg_pkg::coord_t   center_y_i,
  input  cvg_pkg::coord_t   edge_x_i,
  input  cvg_pkg::coord_t   edge_y_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output cvg_pkg::job_t     job_o
);
  import cvg_pkg::*;

  logic         hold_valid_q, hold_valid_d;
  coord_t       hcx_q, hcy_q, hex_q, hey_q;
  front_state_e state_q, state_d;
  logic         take;
  logic         push;

  coord_t              cx_q, cy_q;
  logic signed [16:0]  dx_q, dy_q;
  logic signed [SumW-1:0] sqx_full, sqy_full;
  logic [SumW-1:0]     sqx_q, sqy_q;
  logic [SumW-1:0]     n_q;
  logic [RadiusW:0]    rem_q;
  radius_t             root_q;
  logic [4:0]          step_q;

  logic [RadiusW+2:0]  rem_shift;
  logic [RadiusW+2:0]  trial;
  logic                fits;

  assign in_ready_o = !hold_valid_q;

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (in_valid_i && in_ready_o) begin
      hold_valid_d = 1'b1;
    end else if (take) begin
      hold_valid_d = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      FRONT_IDLE: begin
        if (hold_valid_q) begin
          state_d = FRONT_SQUARE;
        end
      end
      FRONT_SQUARE: state_d = FRONT_SUM;
      FRONT_SUM:    state_d = FRONT_ROOT;
      FRONT_ROOT: begin
        if (step_q == 5'(RootSteps - 1)) begin
          state_d = FRONT_PUSH;
        end
      end
      FRONT_PUSH: begin
        if (job_ready_i) begin
          state_d = FRONT_IDLE;
        end
      end
      default: state_d = FRONT_IDLE;
    endcase
  end

  always_comb begin
    take        = 1'b0;
    job_valid_o = 1'b0;
    case (state_q)
      FRONT_IDLE: take        = hold_valid_q;
      FRONT_PUSH: job_valid_o = 1'b1;
      default: begin
        take        = 1'b0;
        job_valid_o = 1'b0;
      end
    endcase
  end

  assign push = job_valid_o && job_ready_i;

  assign sqx_full = dx_q * dx_q;
  assign sqy_full = dy_q * dy_q;

  assign rem_shift = {rem_q, n_q[SumW-1 -: 2]};
  assign trial     = {1'b0, root_q, 2'b01};
  assign fits      = rem_shift >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      state_q      <= FRONT_IDLE;
    end else begin
      hold_valid_q <= hold_valid_d;
      state_q      <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      hcx_q <= center_x_i;
      hcy_q <= center_y_i;
      hex_q <= edge_x_i;
      hey_q <= edge_y_i;
    end
    case (state_q)
      FRONT_IDLE: begin
        cx_q <= hcx_q;
        cy_q <= hcy_q;
        dx_q <= 17'(hex_q) - 17'(hcx_q);
        dy_q <= 17'(hey_q) - 17'(hcy_q);
      end
      FRONT_SQUARE: begin
        sqx_q <= unsigned'(sqx_full);
        sqy_q <= unsigned'(sqy_full);
      end
      FRONT_SUM: begin
        n_q    <= sqx_q + sqy_q;
        rem_q  <= '0;
        root_q <= '0;
        step_q <= '0;
      end
      FRONT_ROOT: begin
        n_q    <= {n_q[SumW-3:0], 2'b00};
        step_q <= step_q + 5'd1;
        if (fits) begin
          rem_q  <= (RadiusW+1)'(rem_shift - trial);
          root_q <= {root_q[RadiusW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_shift[RadiusW:0];
          root_q <= {root_q[RadiusW-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  assign job_o.cx     = cx_q;
  assign job_o.cy     = cy_q;
  assign job_o.radius = root_q;

  sva_take_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(take && (in_valid_i && in_ready_o)))
    else $error("input holding register loaded and drained in one cycle");
  sva_push_after_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(job_valid_o) |-> $past(state_q) == FRONT_ROOT)
    else $error("job offered without a finished root");
  sva_push_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o && !job_ready_i |=> job_valid_o && $stable(root_q))
    else $error("radius changed while the job waited");

endmodule

@@ hw/rtl/cvg_queue.sv @@
module cvg_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  cvg_pkg::job_t  push_job_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output cvg_pkg::job_t  pop_job_o
);
  import cvg_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign push_ready_o = count_q != 2'd2;
  assign pop_valid_o  = count_q != 2'd0;
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  sva_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");
  sva_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");
  sva_ptr_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 2'd1 |-> wr_ptr_q != rd_ptr_q)
    else $error("queue pointers disagree with count");

endmodule

@@ hw/rtl/cvg_back.sv @@
module cvg_back #(
  parameter int SEGMENTS = 36
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  cvg_pkg::job_t    job_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cvg_pkg::coord_t  vertex_x_o,
  output cvg_pkg::coord_t  vertex_y_o,
  output cvg_pkg::vnum_t   vertex_number_o,
  output logic             last_vertex_o
);
  import cvg_pkg::*;

  localparam int StepQuo = TableSize / SEGMENTS;
  localparam int StepRem = TableSize % SEGMENTS;

  logic        advance, issue, at_last;
  vnum_t       cnt_q;
  logic [5:0]  idx_q, acc_q, idx_next, acc_next;
  logic [6:0]  acc_sum;
  logic        acc_wrap;
  logic [5:0]  sidx_raw, sidx;

  logic                v1_q, v2_q, v3_q;
  trig_t               tc_q, ts_q;
  coord_t              cx1_q, cy1_q, cx2_q, cy2_q;
  radius_t             r1_q;
  vnum_t               num1_q, num2_q, num3_q;
  logic                last1_q, last2_q, last3_q;
  logic signed [SumW-1:0] px_q, py_q;
  logic signed [SumW-1:0] rx, ry;
  logic signed [20:0]  sx, sy;
  coord_t              vx_q, vy_q;

  assign advance     = !v3_q || out_ready_i;
  assign issue       = advance && job_valid_i;
  assign at_last     = cnt_q == NumW'(SEGMENTS);
  assign job_ready_o = advance && at_last;

  // The table index of each rim vertex steps by TableSize/SEGMENTS with the
  // remainder carried, so no division is needed.
  assign acc_sum  = 7'(acc_q) + 7'(StepRem);
  assign acc_wrap = acc_sum >= 7'(SEGMENTS);
  assign acc_next = acc_wrap ? 6'(acc_sum - 7'(SEGMENTS)) : acc_sum[5:0];
  assign idx_next = idx_q + 6'(StepQuo) + {5'd0, acc_wrap};

  assign sidx_raw = idx_q + 6'(SineShift);
  assign sidx     = (sidx_raw >= 6'(TableSize)) ? sidx_raw - 6'(TableSize) : sidx_raw;

  assign rx = (px_q + SumW'(RoundBias)) >>> TrigFrac;
  assign ry = (py_q + SumW'(RoundBias)) >>> TrigFrac;
  assign sx = 21'(cx2_q) + rx[20:0];
  assign sy = 21'(cy2_q) + ry[20:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
      acc_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else if (advance) begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (issue) begin
        cnt_q <= at_last ? '0 : cnt_q + NumW'(1);
        if (cnt_q == '0 || at_last) begin
          idx_q <= '0;
          acc_q <= '0;
        end else begin
          idx_q <= idx_next;
          acc_q <= acc_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (cnt_q == '0) begin
        tc_q <= '0;
        ts_q <= '0;
      end else begin
        tc_q <= cos_q14(idx_q);
        ts_q <= cos_q14(sidx);
      end
      cx1_q   <= job_i.cx;
      cy1_q   <= job_i.cy;
      r1_q    <= job_i.radius;
      num1_q  <= cnt_q;
      last1_q <= at_last;

      px_q    <= SumW'($signed({1'b0, r1_q}) * tc_q);
      py_q    <= SumW'($signed({1'b0, r1_q}) * ts_q);
      cx2_q   <= cx1_q;
      cy2_q   <= cy1_q;
      num2_q  <= num1_q;
      last2_q <= last1_q;

      vx_q    <= sat_coord(sx);
      vy_q    <= sat_coord(sy);
      num3_q  <= num2_q;
      last3_q <= last2_q;
    end
  end

  assign out_valid_o     = v3_q;
  assign vertex_x_o      = vx_q;
  assign vertex_y_o      = vy_q;
  assign vertex_number_o = num3_q;
  assign last_vertex_o   = last3_q;

  sva_last_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_vertex_o |-> vertex_number_o == NumW'(SEGMENTS))
    else $error("last vertex carries the wrong number");
  sva_number_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> vertex_number_o <= NumW'(SEGMENTS))
    else $error("vertex number out of range");
  sva_pop_at_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i && job_ready_o |=> cnt_q == '0)
    else $error("job released before its last vertex");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import cvg_pkg::*;

  localparam int Segments  = 36;
  localparam int MaxReport = 40;

  typedef struct packed {
    coord_t x;
    coord_t y;
    vnum_t  num;
    logic   last;
  } fan_vertex_t;

  typedef enum int {
    SINK_OPEN,
    SINK_BUSY_LIGHT,
    SINK_BUSY_HEAVY,
    SINK_LONG_STALLS
  } sink_mode_e;

  typedef enum int {
    ANY_POINTS,
    SMALL_RADIUS,
    DEGENERATE,
    NEAR_EDGE
  } circle_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // center_x, center_y, edge_x, edge_y
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // vertex_x, vertex_y, vertex_number, two zero bits
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  fan_vertex_t fan_q[$];
  int          errors = 0;
  int          circles_sent = 0;
  int          vertices_checked = 0;
  int          burst_left = 0;

  sink_mode_e  sink_mode = SINK_OPEN;
  int          sink_mode_left = 0;
  int          sink_run_left = 0;
  logic        sink_level = 1'b1;

  circle_vertex_generator #(
    .SEGMENTS(Segments)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("testbench failed");
    $finish;
  end

  function automatic int quarter_cos(input int j);
    int v;
    case (j)
      0: v = 16384;
      1: v = 16135;
      2: v = 15396;
      3: v = 14189;
      4: v = 12551;
      5: v = 10531;
      6: v = 8192;
      7: v = 5604;
      8: v = 2845;
      default: v = 0;
    endcase
    return v;
  endfunction

  function automatic longint step_cos(input int k);
    int q;
    longint v;
    q = k % TableSize;
    if (q <= 9) begin
      v = quarter_cos(q);
    end else if (q <= 18) begin
      v = -quarter_cos(18 - q);
    end else if (q <= 27) begin
      v = -quarter_cos(q - 18);
    end else begin
      v = quarter_cos(36 - q);
    end
    return v;
  endfunction

  function automatic longint floor_sqrt(input longint n);
    longint root;
    longint trial;
    root = 0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= n) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic coord_t clamp_coord(input longint v);
    coord_t r;
    if (v > 32767) begin
      r = 16'sh7fff;
    end else if (v < -32768) begin
      r = 16'sh8000;
    end else begin
      r = coord_t'(v);
    end
    return r;
  endfunction

  function automatic longint rim_offset(input longint rad, input int idx);
    return (rad * step_cos(idx) + RoundBias) >>> TrigFrac;
  endfunction

  function automatic void predict_fan(input coord_t cx, input coord_t cy,
                                      input coord_t ex, input coord_t ey);
    longint dx;
    longint dy;
    longint rad;
    int cos_idx;
    int sin_idx;
    fan_vertex_t v;
    dx = longint'(ex) - longint'(cx);
    dy = longint'(ey) - longint'(cy);
    rad = floor_sqrt(dx * dx + dy * dy);
    v.x = cx;
    v.y = cy;
    v.num = '0;
    v.last = 1'b0;
    fan_q = {fan_q, v};
    for (int step = 0; step < Segments; step++) begin
      cos_idx = (step * TableSize / Segments) % TableSize;
      sin_idx = (cos_idx + SineShift) % TableSize;
      v.x = clamp_coord(longint'(cx) + rim_offset(rad, cos_idx));
      v.y = clamp_coord(longint'(cy) + rim_offset(rad, sin_idx));
      v.num = vnum_t'(step + 1);
      v.last = (step == Segments - 1);
      fan_q = {fan_q, v};
    end
  endfunction

  task automatic report_mismatch(input string field, input longint want, input longint got);
    errors++;
    if (errors <= MaxReport) begin
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endtask

  always @(posedge clk_i) begin : vertex_check
    fan_vertex_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (fan_q.size() == 0) begin
        errors++;
        if (errors <= MaxReport) begin
          $error("vertex beat with no circle pending: tdata %h", m_axis_tdata);
        end
      end else begin
        want = fan_q.pop_front();
        vertices_checked++;
        if (m_axis_tdata[15:0] !== want.x) begin
          report_mismatch("vertex_x", want.x, $signed(m_axis_tdata[15:0]));
        end
        if (m_axis_tdata[31:16] !== want.y) begin
          report_mismatch("vertex_y", want.y, $signed(m_axis_tdata[31:16]));
        end
        if (m_axis_tdata[37:32] !== want.num) begin
          report_mismatch("vertex_number", want.num, m_axis_tdata[37:32]);
        end
        if (m_axis_tdata[39:38] !== 2'b00) begin
          report_mismatch("tdata padding", 0, m_axis_tdata[39:38]);
        end
        if (m_axis_tlast !== want.last) begin
          report_mismatch("last_vertex", want.last, m_axis_tlast);
        end
      end
    end
  end

  always @(posedge clk_i) begin : sink_pattern
    if (sink_mode_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_mode_left = $urandom_range(50, 400);
    end else begin
      sink_mode_left--;
    end
    case (sink_mode)
      SINK_OPEN: begin
        m_axis_tready <= 1'b1;
      end
      SINK_BUSY_LIGHT: begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
      SINK_BUSY_HEAVY: begin
        m_axis_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        if (sink_run_left == 0) begin
          sink_level = ~sink_level;
          sink_run_left = sink_level ? $urandom_range(1, 20) : $urandom_range(1, 40);
        end else begin
          sink_run_left--;
        end
        m_axis_tready <= sink_level;
      end
    endcase
  end

  task automatic send_circle(input coord_t cx, input coord_t cy,
                             input coord_t ex, input coord_t ey);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
    s_axis_tdata <= {ey, ex, cy, cx};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_fan(cx, cy, ex, ey);
    circles_sent++;
    burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 50);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    if (burst_left != 0) begin
      burst_left = 0;
      s_axis_tvalid <= 1'b0;
    end
    while (fan_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    send_circle(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_circle(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_circle(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_circle(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    send_circle(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
    send_circle(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_circle(16'sh8000, 16'sd0, 16'sh7fff, 16'sd0);
    send_circle(16'sd0, 16'sd0, 16'sh7fff, 16'sd0);
    send_circle(16'sd0, 16'sd0, 16'sd0, 16'sh8000);
    send_circle(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    send_circle(16'sd0, 16'sd0, 16'sd3, 16'sd4);
    send_circle(16'sd100, -16'sd100, 16'sd101, -16'sd99);
    send_circle(-16'sd20000, 16'sd20000, 16'sd20000, -16'sd20000);
  endtask

  task automatic test_rounding_halves();
    send_circle(16'sd0, 16'sd0, 16'sd1, 16'sd0);
    send_circle(16'sd0, 16'sd0, 16'sd0, -16'sd3);
    send_circle(-16'sd1, -16'sd1, -16'sd2, -16'sd1);
    send_circle(16'sd5, 16'sd5, 16'sd5, 16'sd7);
    send_circle(16'sh7ffe, 16'sh8001, 16'sh7fff, 16'sh8001);
    send_circle(-16'sd4096, 16'sd4096, -16'sd4091, 16'sd4096);
  endtask

  task automatic send_random_circle();
    circle_kind_e kind;
    coord_t cx;
    coord_t cy;
    coord_t ex;
    coord_t ey;
    kind = circle_kind_e'($urandom_range(0, 3));
    cx = coord_t'($urandom);
    cy = coord_t'($urandom);
    case (kind)
      ANY_POINTS: begin
        ex = coord_t'($urandom);
        ey = coord_t'($urandom);
      end
      SMALL_RADIUS: begin
        ex = clamp_coord(longint'(cx) + $urandom_range(0, 128) - 64);
        ey = clamp_coord(longint'(cy) + $urandom_range(0, 128) - 64);
      end
      DEGENERATE: begin
        ex = cx;
        ey = cy;
      end
      default: begin
        cx = ($urandom_range(0, 1) != 0) ? coord_t'(32767 - $urandom_range(0, 300))
                                         : coord_t'(-32768 + $urandom_range(0, 300));
        ex = clamp_coord(longint'(cx) + $urandom_range(0, 8192) - 4096);
        ey = clamp_coord(longint'(cy) + $urandom_range(0, 8192) - 4096);
      end
    endcase
    send_circle(cx, cy, ex, ey);
  endtask

  task automatic test_pause_until_drained();
    repeat (8) send_random_circle();
    wait_drained();
    repeat (8) send_random_circle();
  endtask

  task automatic test_random_circles(input int count);
    repeat (count) send_random_circle();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_rounding_halves();
    test_random_circles(140);
    test_pause_until_drained();
    test_random_circles(144);
    wait_drained();
    repeat (60) @(posedge clk_i);
    $display("Checked %0d vertices from %0d circles under random source gaps and sink stalls.",
             vertices_checked, circles_sent);
    $display("Cases: zero, unit and maximum radius, corner centers, saturation, half-step rounding.");
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
